FILE: hw/rtl/pxdec_pkg.sv
// Package for the percent and XML entity decoder.
// Holds payload structs, the match result type, entity tables and hex helpers.
// No dependencies.
package pxdec_pkg;

    localparam int BUF_DEPTH   = 6;
    localparam int HOLD_DEPTH  = 5;
    localparam int CNT_W       = 3;
    localparam int PCT_LEN     = 3;
    localparam int ENT_NUM     = 4;
    localparam int ENT_MAX_LEN = 6;

    localparam logic [7:0] CHR_PERCENT = "%";
    localparam logic [7:0] CHR_AMP     = "&";

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    typedef logic [BUF_DEPTH-1:0][7:0] hold_buf_t;

    typedef enum logic [1:0] {
        MK_NONE,
        MK_PARTIAL,
        MK_FULL
    } match_kind_t;

    typedef struct packed {
        match_kind_t      kind;
        logic [CNT_W-1:0] len;
        logic [7:0]       value;
    } match_t;

    localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAX_LEN] = '{
        '{"&", "a", "m", "p", ";", 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00},
        '{"&", "q", "u", "o", "t", ";"}
    };

    localparam logic [CNT_W-1:0] ENT_LEN [ENT_NUM] = '{3'd5, 3'd4, 3'd4, 3'd6};

    localparam logic [7:0] ENT_VALUE [ENT_NUM] = '{"&", "<", ">", 8'h22};

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    // Letters of either case share the low nibble 1..6.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c <= "9") begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

endpackage

FILE: hw/rtl/pxdec_match.sv
// Classifier for the head of the byte buffer: no match, proper prefix or full escape.
// Depends on pxdec_pkg.
module pxdec_match
    import pxdec_pkg::*;
(
    input  hold_buf_t        bytes_i,
    input  logic [CNT_W-1:0] count_i,
    output match_t           match_o
);

    always_comb begin
        logic ok;
        logic hit;
        match_o.kind  = MK_NONE;
        match_o.len   = CNT_W'(1);
        match_o.value = bytes_i[0];
        hit           = 1'b0;
        ok            = 1'b0;
        if (bytes_i[0] == CHR_PERCENT) begin
            if (count_i >= CNT_W'(2) && !is_hex(bytes_i[1])) begin
                match_o.kind = MK_NONE;
            end else if (count_i >= CNT_W'(PCT_LEN) && !is_hex(bytes_i[2])) begin
                match_o.kind = MK_NONE;
            end else if (count_i < CNT_W'(PCT_LEN)) begin
                match_o.kind = MK_PARTIAL;
            end else begin
                match_o.kind  = MK_FULL;
                match_o.len   = CNT_W'(PCT_LEN);
                match_o.value = {hex_val(bytes_i[1]), hex_val(bytes_i[2])};
            end
        end else if (bytes_i[0] == CHR_AMP) begin
            for (int e = 0; e < ENT_NUM; e++) begin
                ok = 1'b1;
                for (int k = 1; k < ENT_MAX_LEN; k++) begin
                    if (CNT_W'(k) < ENT_LEN[e] && CNT_W'(k) < count_i &&
                        bytes_i[k] != ENT_TEXT[e][k]) begin
                        ok = 1'b0;
                    end
                end
                if (ok && !hit) begin
                    hit = 1'b1;
                    if (count_i < ENT_LEN[e]) begin
                        match_o.kind = MK_PARTIAL;
                    end else begin
                        match_o.kind  = MK_FULL;
                        match_o.len   = ENT_LEN[e];
                        match_o.value = ENT_VALUE[e];
                    end
                end
            end
        end
    end

endmodule

FILE: hw/rtl/percent_and_xml_entity_decoder_unit.sv
// Top level of the percent and XML entity decoder.
// Depends on pxdec_pkg and pxdec_match.
//
// Usage:
//   s_ channel carries one raw byte per transaction, with in_last on the final
//   byte of a string. m_ channel carries one decoded byte per transaction, with
//   run_last on the final result of an input byte and string_end on the final
//   result of the string.
//   Bytes that may still start %XX, &amp;, &lt;, &gt; or &quot; are held in a
//   six-byte buffer. Each cycle the head of the buffer is classified; while
//   the output register is free, one result goes to the output register.
//   A completing byte is written into the buffer register, and its result is
//   then written into the output register. Throughput: one byte per cycle
//   while each byte gives at most one result and the receiver keeps up; a
//   failed match gives one extra result per cycle for each further held byte,
//   and the input is held off meanwhile (up to six results for one byte).
//   Reset clears the buffer count and the output valid; buffer contents are
//   not reset. When the receiver stalls, the output register holds its result
//   and the input is taken only while the buffer holds nothing ready to emit.
module percent_and_xml_entity_decoder_unit
    import pxdec_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    hold_buf_t        bytes_reg;
    hold_buf_t        bytes_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             last_reg;
    logic             last_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;

    match_t           cur_match;
    match_t           rem_match;
    hold_buf_t        rem_bytes;
    logic [CNT_W-1:0] rem_count;
    hold_buf_t        base_bytes;
    logic [CNT_W-1:0] base_count;
    logic             cur_idle;
    logic             rem_idle;
    logic             out_free;
    logic             emit;
    logic             accept;

    pxdec_match u_cur_match (
        .bytes_i (bytes_reg),
        .count_i (count_reg),
        .match_o (cur_match)
    );

    assign rem_bytes = bytes_reg >> {cur_match.len, 3'b000};
    assign rem_count = count_reg - cur_match.len;

    pxdec_match u_rem_match (
        .bytes_i (rem_bytes),
        .count_i (rem_count),
        .match_o (rem_match)
    );

    assign cur_idle = (count_reg == '0) || (cur_match.kind == MK_PARTIAL && !last_reg);
    assign rem_idle = (rem_count == '0) || (rem_match.kind == MK_PARTIAL && !last_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = !cur_idle && out_free;
    assign s_ready  = cur_idle || (emit && rem_idle);
    assign accept   = s_valid && s_ready;

    always_comb begin
        base_bytes   = emit ? rem_bytes : bytes_reg;
        base_count   = emit ? rem_count : count_reg;
        bytes_next   = base_bytes;
        count_next   = base_count;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            for (int k = 0; k < BUF_DEPTH; k++) begin
                if (CNT_W'(k) == base_count) begin
                    bytes_next[k] = s_data.in_byte;
                end
            end
            count_next = base_count + CNT_W'(1);
            last_next  = s_data.in_last;
        end
        if (emit) begin
            m_valid_next           = 1'b1;
            m_data_next.out_byte   = cur_match.value;
            m_data_next.run_last   = rem_idle;
            m_data_next.string_end = rem_idle && last_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
        bytes_reg  <= bytes_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_idle |-> count_reg <= CNT_W'(HOLD_DEPTH))
        else $error("held bytes exceed hold depth while waiting for input");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.string_end |-> m_data_reg.run_last)
        else $error("string end without run last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && last_reg && rem_idle && !accept |=> count_reg == '0)
        else $error("bytes left in buffer after end of string");

endmodule

FILE: dv/tb_percent_and_xml_entity_decoder_unit.sv
// Self-checking testbench for percent_and_xml_entity_decoder_unit: directed and random strings,
// random idling on both channels, decoded bytes checked against an in-bench decoder.
// Depends on pxdec_pkg and the decoder RTL.
module tb_percent_and_xml_entity_decoder_unit;
    import pxdec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200;
    localparam int RANDOM_BYTES = 130;
    localparam int CALM_TAIL = 40;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] ENTITY_TXT [4][6] = '{
        '{"&", "a", "m", "p", ";", 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00},
        '{"&", "q", "u", "o", "t", ";"}
    };
    localparam int ENTITY_LEN [4] = '{5, 4, 4, 6};
    localparam logic [7:0] ENTITY_OUT [4] = '{"&", "<", ">", 8'h22};

    class decode_scoreboard;
        logic [7:0] held_q[$];
        out_item_t pending_q[$];
        int unsigned bytes_in;
        int unsigned strings_seen;
        int unsigned decoded_out;
        int unsigned escapes_hit;
        int unsigned mismatches;

        function logic [4:0] nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9") begin
                return 5'(c - "0");
            end
            if (c >= "a" && c <= "f") begin
                return 5'(c - "a" + 8'd10);
            end
            if (c >= "A" && c <= "F") begin
                return 5'(c - "A" + 8'd10);
            end
            return 5'd16;
        endfunction

        function match_kind_t classify(input logic [7:0] w[$], output int len,
                                       output logic [7:0] val);
            int n;
            int lim;
            logic ok;
            logic [4:0] hi;
            logic [4:0] lo;
            n = w.size();
            len = 1;
            val = w[0];
            if (w[0] == CHR_PERCENT) begin
                lim = (n < 3) ? n : 3;
                for (int k = 1; k < lim; k++) begin
                    if (nibble_of(w[k]) > 5'd15) begin
                        return MK_NONE;
                    end
                end
                if (n < 3) begin
                    return MK_PARTIAL;
                end
                hi = nibble_of(w[1]);
                lo = nibble_of(w[2]);
                len = 3;
                val = {hi[3:0], lo[3:0]};
                return MK_FULL;
            end
            if (w[0] == CHR_AMP) begin
                for (int e = 0; e < 4; e++) begin
                    lim = (n < ENTITY_LEN[e]) ? n : ENTITY_LEN[e];
                    ok = 1'b1;
                    for (int k = 1; k < lim; k++) begin
                        if (w[k] != ENTITY_TXT[e][k]) begin
                            ok = 1'b0;
                        end
                    end
                    if (ok) begin
                        if (n < ENTITY_LEN[e]) begin
                            return MK_PARTIAL;
                        end
                        len = ENTITY_LEN[e];
                        val = ENTITY_OUT[e];
                        return MK_FULL;
                    end
                end
            end
            return MK_NONE;
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        // Accepted input transaction: work out every decoded byte it releases.
        function void take_raw_byte(in_item_t it);
            logic [7:0] window[$];
            out_item_t run[$];
            out_item_t r;
            match_kind_t kind;
            int len;
            logic [7:0] val;
            window = held_q;
            window.push_back(it.in_byte);
            bytes_in++;
            if (it.in_last) begin
                strings_seen++;
            end
            while (window.size() > 0) begin
                kind = classify(window, len, val);
                if (kind == MK_PARTIAL && !it.in_last) begin
                    break;
                end
                if (kind == MK_FULL) begin
                    escapes_hit++;
                end else begin
                    len = 1;
                    val = window[0];
                end
                r.out_byte = val;
                r.run_last = 1'b0;
                r.string_end = 1'b0;
                run.push_back(r);
                repeat (len) void'(window.pop_front());
            end
            held_q = window;
            if (run.size() > 0) begin
                run[run.size() - 1].run_last = 1'b1;
                run[run.size() - 1].string_end = it.in_last;
            end
            foreach (run[i]) begin
                pending_q.push_back(run[i]);
            end
        endfunction

        function void check_decoded(out_item_t got);
            out_item_t want;
            decoded_out++;
            if (pending_q.size() == 0) begin
                note_failure($sformatf("unexpected decoded byte %02h run_last %0b string_end %0b",
                                       got.out_byte, got.run_last, got.string_end));
                return;
            end
            want = pending_q.pop_front();
            if (got.out_byte != want.out_byte || got.run_last != want.run_last ||
                got.string_end != want.string_end) begin
                note_failure($sformatf(
                    "mismatch: exp byte %02h run_last %0b string_end %0b, got %02h %0b %0b",
                    want.out_byte, want.run_last, want.string_end,
                    got.out_byte, got.run_last, got.string_end));
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    logic jitter_on = 1'b1;
    in_item_t stim_q[$];
    decode_scoreboard sb = new;

    percent_and_xml_entity_decoder_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Output checked before input noted: a result never depends on the same-edge input.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_decoded(m_data);
            end
            if (s_valid && s_ready) begin
                sb.take_raw_byte(s_data);
            end
        end
    end

    function automatic void add_byte(logic [7:0] b, logic ends);
        in_item_t it;
        it.in_byte = b;
        it.in_last = ends;
        stim_q.push_back(it);
    endfunction

    function automatic void add_text(string s, logic ends);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i], ends && (i == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] hex_char();
        int unsigned d;
        d = $urandom_range(0, 15);
        if (d < 10) begin
            return 8'("0" + d);
        end
        return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
    endfunction

    function automatic void add_random_string();
        int unsigned e;
        int unsigned cut;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                3, 4: begin
                    add_byte(CHR_PERCENT, 1'b0);
                    add_byte(hex_char(), 1'b0);
                    add_byte(hex_char(), 1'b0);
                end
                5, 6: begin
                    e = $urandom_range(0, 3);
                    for (int k = 0; k < ENTITY_LEN[e]; k++) begin
                        add_byte(ENTITY_TXT[e][k], 1'b0);
                    end
                end
                7: begin
                    e = $urandom_range(0, 3);
                    cut = $urandom_range(1, ENTITY_LEN[e] - 1);
                    for (int k = 0; k < cut; k++) begin
                        add_byte(ENTITY_TXT[e][k], 1'b0);
                    end
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                8: begin
                    add_byte(CHR_PERCENT, 1'b0);
                    if ($urandom_range(0, 1)) begin
                        add_byte(hex_char(), 1'b0);
                    end
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                default: begin
                    add_byte($urandom_range(0, 1) ? CHR_PERCENT : CHR_AMP, 1'b0);
                end
            endcase
        end
        stim_q[stim_q.size() - 1].in_last = 1'b1;
    endfunction

    // Entered and left at a falling edge; valid stays high between back-to-back transactions.
    task automatic send_raw(in_item_t it);
        if (jitter_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        int hold;
        hold = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold == 0 && jitter_on && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(1, 5);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("percent_and_xml_entity_decoder_unit regression: fail");
        $finish;
    end

    initial begin
        int directed_len;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero, mixed-case hex, percent cut short at end of string
        add_text("%00%fF%A", 1'b1);
        add_text("&lt;&quot;", 1'b1);
        // entity cut short at end of string
        add_text("&amp;&g", 1'b1);
        // extremes and a bad hex digit
        add_byte(8'hFF, 1'b0);
        add_text("%Z", 1'b0);
        add_byte(8'h00, 1'b1);
        directed_len = stim_q.size();
        while (stim_q.size() < directed_len + RANDOM_BYTES) begin
            add_random_string();
        end

        foreach (stim_q[i]) begin
            if (i >= stim_q.size() - CALM_TAIL) begin
                jitter_on = 1'b0;
            end
            send_raw(stim_q[i]);
        end
        s_valid <= 1'b0;

        while (sb.pending_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (sb.pending_q.size() != 0) begin
            sb.note_failure($sformatf("%0d decoded bytes never arrived", sb.pending_q.size()));
        end

        $display("Run covered %0d raw bytes in %0d strings, %0d escapes decoded.",
                 sb.bytes_in, sb.strings_seen, sb.escapes_hit);
        $display("%0d decoded bytes checked, %0d failures.", sb.decoded_out, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("percent_and_xml_entity_decoder_unit regression: pass");
        end else begin
            $display("percent_and_xml_entity_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule
